// ----- rtl/pbf_pkg.sv -----
// ----------------------------------------------------------------------------
// pbf_pkg: shared types and helpers for the path bezier flattener
// Command codes, the job record passed from front to back, and saturation.
// ----------------------------------------------------------------------------
package pbf_pkg;

  localparam int unsigned CoordW = 32;

  localparam logic [3:0] MODE_MOVE   = 4'd0;
  localparam logic [3:0] MODE_LINE   = 4'd1;
  localparam logic [3:0] MODE_HLINE  = 4'd2;
  localparam logic [3:0] MODE_VLINE  = 4'd3;
  localparam logic [3:0] MODE_CUBIC  = 4'd4;
  localparam logic [3:0] MODE_QUAD   = 4'd5;
  localparam logic [3:0] MODE_SCUBIC = 4'd6;
  localparam logic [3:0] MODE_SQUAD  = 4'd7;
  localparam logic [3:0] MODE_CLOSE  = 4'd8;

  typedef logic signed [CoordW-1:0] coord_t;

  // Work for the back end: a curve (cubic or quadratic) or one or two points.
  typedef struct packed {
    logic [3:0][CoordW-1:0] px;
    logic [3:0][CoordW-1:0] py;
    logic                   is_curve;
    logic                   is_quad;
    logic                   two_pts;
  } job_t;

  // Clamp a wide sum to the signed 32-bit range.
  function automatic coord_t sat32(input logic signed [CoordW+1:0] v);
    coord_t r;
    if (v > $signed({{2{1'b0}}, 1'b0, {(CoordW-1){1'b1}}})) begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end else if (v < $signed({{2{1'b1}}, 1'b1, {(CoordW-1){1'b0}}})) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/path_bezier_flattener_top.sv -----
// ----------------------------------------------------------------------------
// Latency: a command's first point passes the job queue, the job register and
// the three-level interpolation pipeline (s1, s2 and output registers).
// Throughput: one point per cycle while the output is ready; a curve gives
// SEGMENTS+1 points, line or close one, h/v line one or two, move none.
// Reset (rst_ni low, asynchronous) clears pen, start, control and the queue.
// ----------------------------------------------------------------------------
// path_bezier_flattener_top
// Flattens decoded path commands into polyline points by de Casteljau.
// ----------------------------------------------------------------------------
module path_bezier_flattener_top #(
  parameter int unsigned SEGMENTS  = 20,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [3:0]      mode_i,
  input  logic            relative_i,
  input  pbf_pkg::coord_t first_x_i,
  input  pbf_pkg::coord_t first_y_i,
  input  pbf_pkg::coord_t second_x_i,
  input  pbf_pkg::coord_t second_y_i,
  input  pbf_pkg::coord_t third_x_i,
  input  pbf_pkg::coord_t third_y_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pbf_pkg::coord_t point_x_o,
  output pbf_pkg::coord_t point_y_o,
  output logic            last_point_o
);
  logic          q_full, q_push, q_pop, q_valid, accept;
  pbf_pkg::job_t push_job, q_job;

  // Take a request whenever the job queue has room; moves only set the pen
  // and subpath start, unused codes change nothing, and neither pushes a job.
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && !q_full;

  pbf_front u_front (
    .clk_i, .rst_ni,
    .accept_i  (accept),
    .mode_i, .relative_i,
    .first_x_i, .first_y_i, .second_x_i, .second_y_i, .third_x_i, .third_y_i,
    .push_o    (q_push),
    .job_o     (push_job)
  );

  // Two jobs of slack let decode run ahead of a stalled output.
  pbf_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (q_push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_job)
  );

  // Back end: steps t, runs the interpolation levels, holds the output.
  pbf_back #(.SEGMENTS(SEGMENTS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_data_i  (q_job),
    .q_pop_o   (q_pop),
    .out_valid_o, .out_ready_i, .point_x_o, .point_y_o, .last_point_o
  );

endmodule

// ----- rtl/pbf_lerp.sv -----
// ----------------------------------------------------------------------------
// pbf_lerp: fixed-point linear interpolation
// y = a + floor(((b - a) * t + half) / 2^FRAC_BITS), rounding half up.
// ----------------------------------------------------------------------------
module pbf_lerp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  pbf_pkg::coord_t      a_i,
  input  pbf_pkg::coord_t      b_i,
  input  logic [FRAC_BITS:0]   t_i,
  output pbf_pkg::coord_t      y_o
);
  localparam int unsigned PW = FRAC_BITS + 35;

  logic signed [32:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] shd;

  assign diff = $signed({b_i[31], b_i}) - $signed({a_i[31], a_i});
  assign prod = PW'(diff) * PW'($signed({1'b0, t_i}));
  assign rnd  = prod + (PW'(1) <<< (FRAC_BITS - 1));
  assign shd  = rnd >>> FRAC_BITS;
  assign y_o  = a_i + shd[31:0];

endmodule

// ----- rtl/pbf_queue.sv -----
// ----------------------------------------------------------------------------
// pbf_queue: two-entry job queue
// Decouples command decode from point generation.
// ----------------------------------------------------------------------------
module pbf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pbf_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pbf_pkg::job_t data_o
);
  pbf_pkg::job_t mem_q [2];
  logic          wr_q, wr_d, rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/pbf_front.sv -----
// ----------------------------------------------------------------------------
// pbf_front: command decode
// Resolve coordinates, track pen, subpath start and control, build jobs.
// ----------------------------------------------------------------------------
module pbf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [3:0]      mode_i,
  input  logic            relative_i,
  input  pbf_pkg::coord_t first_x_i,
  input  pbf_pkg::coord_t first_y_i,
  input  pbf_pkg::coord_t second_x_i,
  input  pbf_pkg::coord_t second_y_i,
  input  pbf_pkg::coord_t third_x_i,
  input  pbf_pkg::coord_t third_y_i,
  output logic            push_o,
  output pbf_pkg::job_t   job_o
);
  pbf_pkg::coord_t pen_x_q, pen_y_q, start_x_q, start_y_q, ctrl_x_q, ctrl_y_q;
  pbf_pkg::coord_t pen_x_d, pen_y_d, start_x_d, start_y_d, ctrl_x_d, ctrl_y_d;
  logic            has_q, has_d;
  pbf_pkg::coord_t ax, ay, bx, by, cx, cy, rx, ry;
  logic            emit;

  function automatic pbf_pkg::coord_t rel_add(input pbf_pkg::coord_t v,
                                               input pbf_pkg::coord_t p,
                                               input logic rel);
    pbf_pkg::coord_t r;
    if (rel) begin
      r = pbf_pkg::sat32(34'($signed(v)) + 34'($signed(p)));
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    ax = rel_add(first_x_i, pen_x_q, relative_i);
    ay = rel_add(first_y_i, pen_y_q, relative_i);
    bx = rel_add(second_x_i, pen_x_q, relative_i);
    by = rel_add(second_y_i, pen_y_q, relative_i);
    cx = rel_add(third_x_i, pen_x_q, relative_i);
    cy = rel_add(third_y_i, pen_y_q, relative_i);
    // reflect the stored control about the pen
    rx = pbf_pkg::sat32((34'($signed(pen_x_q)) <<< 1) - 34'($signed(ctrl_x_q)));
    ry = pbf_pkg::sat32((34'($signed(pen_y_q)) <<< 1) - 34'($signed(ctrl_y_q)));

    pen_x_d   = pen_x_q;
    pen_y_d   = pen_y_q;
    start_x_d = start_x_q;
    start_y_d = start_y_q;
    ctrl_x_d  = ctrl_x_q;
    ctrl_y_d  = ctrl_y_q;
    emit      = 1'b0;
    job_o     = '0;

    case (mode_i)
      pbf_pkg::MODE_MOVE: begin
        pen_x_d   = ax;
        pen_y_d   = ay;
        start_x_d = ax;
        start_y_d = ay;
      end
      pbf_pkg::MODE_LINE: begin
        emit       = 1'b1;
        job_o.px[0] = ax;
        job_o.py[0] = ay;
      end
      pbf_pkg::MODE_HLINE, pbf_pkg::MODE_VLINE: begin
        emit          = 1'b1;
        job_o.two_pts = !has_q;
        job_o.px[0]   = pen_x_q;
        job_o.py[0]   = pen_y_q;
        job_o.px[1]   = (mode_i == pbf_pkg::MODE_HLINE) ? ax : pen_x_q;
        job_o.py[1]   = (mode_i == pbf_pkg::MODE_HLINE) ? pen_y_q : ay;
        if (has_q) begin
          job_o.px[0] = job_o.px[1];
          job_o.py[0] = job_o.py[1];
        end
      end
      pbf_pkg::MODE_CUBIC: begin
        emit           = 1'b1;
        job_o.is_curve = 1'b1;
        job_o.px       = {cx, bx, ax, pen_x_q};
        job_o.py       = {cy, by, ay, pen_y_q};
        ctrl_x_d       = bx;
        ctrl_y_d       = by;
      end
      pbf_pkg::MODE_QUAD: begin
        emit           = 1'b1;
        job_o.is_curve = 1'b1;
        job_o.is_quad  = 1'b1;
        job_o.px       = {bx, bx, ax, pen_x_q};
        job_o.py       = {by, by, ay, pen_y_q};
        ctrl_x_d       = ax;
        ctrl_y_d       = ay;
      end
      pbf_pkg::MODE_SCUBIC: begin
        emit           = 1'b1;
        job_o.is_curve = 1'b1;
        job_o.px       = {bx, ax, rx, pen_x_q};
        job_o.py       = {by, ay, ry, pen_y_q};
        ctrl_x_d       = ax;
        ctrl_y_d       = ay;
      end
      pbf_pkg::MODE_SQUAD: begin
        emit           = 1'b1;
        job_o.is_curve = 1'b1;
        job_o.is_quad  = 1'b1;
        job_o.px       = {ax, ax, rx, pen_x_q};
        job_o.py       = {ay, ay, ry, pen_y_q};
        ctrl_x_d       = rx;
        ctrl_y_d       = ry;
      end
      pbf_pkg::MODE_CLOSE: begin
        emit        = 1'b1;
        job_o.px[0] = start_x_q;
        job_o.py[0] = start_y_q;
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    // the pen ends on the last point the job emits
    if (emit) begin
      if (job_o.is_curve) begin
        pen_x_d = job_o.is_quad ? job_o.px[2] : job_o.px[3];
        pen_y_d = job_o.is_quad ? job_o.py[2] : job_o.py[3];
      end else begin
        pen_x_d = job_o.two_pts ? job_o.px[1] : job_o.px[0];
        pen_y_d = job_o.two_pts ? job_o.py[1] : job_o.py[0];
      end
    end
    has_d  = has_q | emit;
    push_o = accept_i & emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q   <= '0;
      pen_y_q   <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
      ctrl_x_q  <= '0;
      ctrl_y_q  <= '0;
      has_q     <= 1'b0;
    end else if (accept_i) begin
      pen_x_q   <= pen_x_d;
      pen_y_q   <= pen_y_d;
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
      ctrl_x_q  <= ctrl_x_d;
      ctrl_y_q  <= ctrl_y_d;
      has_q     <= has_d;
    end
  end

endmodule

// ----- rtl/pbf_back.sv -----
// ----------------------------------------------------------------------------
// pbf_back: point generator
// Step t over a job and run three de Casteljau levels, one per stage.
// ----------------------------------------------------------------------------
module pbf_back #(
  parameter int unsigned SEGMENTS  = 20,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  pbf_pkg::job_t   q_data_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pbf_pkg::coord_t point_x_o,
  output pbf_pkg::coord_t point_y_o,
  output logic            last_point_o
);
  localparam int unsigned SW = $clog2(SEGMENTS + 1);
  localparam int unsigned RW = $clog2(SEGMENTS) + 1;
  localparam int unsigned TQ = (1 << FRAC_BITS) / SEGMENTS;
  localparam int unsigned TR = (1 << FRAC_BITS) % SEGMENTS;

  logic                 en;
  logic                 job_v_q;
  pbf_pkg::job_t        job_q;
  logic [SW-1:0]        step_q, last_idx;
  logic [FRAC_BITS:0]   t_q, t_d;
  logic [RW-1:0]        r_q, r_d, r_sum;
  logic                 done;
  pbf_pkg::coord_t      ix [4];
  pbf_pkg::coord_t      iy [4];

  logic                 s1_v_q, s1_quad_q, s1_last_q;
  logic [FRAC_BITS:0]   s1_t_q;
  pbf_pkg::coord_t      s1_x_q [3];
  pbf_pkg::coord_t      s1_y_q [3];
  pbf_pkg::coord_t      l1_x [3];
  pbf_pkg::coord_t      l1_y [3];

  logic                 s2_v_q, s2_quad_q, s2_last_q;
  logic [FRAC_BITS:0]   s2_t_q;
  pbf_pkg::coord_t      s2_x_q [2];
  pbf_pkg::coord_t      s2_y_q [2];
  pbf_pkg::coord_t      l2_x [2];
  pbf_pkg::coord_t      l2_y [2];
  pbf_pkg::coord_t      l3_x, l3_y;

  logic                 out_v_q, out_last_q;
  pbf_pkg::coord_t      out_x_q, out_y_q;

  assign en = !out_v_q || out_ready_i;

  always_comb begin
    if (job_q.is_curve) begin
      last_idx = SW'(SEGMENTS);
    end else begin
      last_idx = {{(SW-1){1'b0}}, job_q.two_pts};
    end
    done = job_v_q && (step_q == last_idx);
    q_pop_o = en && (!job_v_q || done) && q_valid_i;

    r_sum = r_q + RW'(TR);
    if (r_sum >= RW'(SEGMENTS)) begin
      r_d = r_sum - RW'(SEGMENTS);
      t_d = t_q + (FRAC_BITS+1)'(TQ) + 1'b1;
    end else begin
      r_d = r_sum;
      t_d = t_q + (FRAC_BITS+1)'(TQ);
    end

    // point jobs: all four controls equal, so every level passes the point
    for (int k = 0; k < 4; k++) begin
      if (job_q.is_curve) begin
        ix[k] = job_q.px[k];
        iy[k] = job_q.py[k];
      end else begin
        ix[k] = job_q.px[{1'b0, step_q[0]}];
        iy[k] = job_q.py[{1'b0, step_q[0]}];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lvl1
    pbf_lerp #(.FRAC_BITS(FRAC_BITS)) u_lx (
      .a_i(ix[g]), .b_i(ix[g+1]), .t_i(t_q), .y_o(l1_x[g]));
    pbf_lerp #(.FRAC_BITS(FRAC_BITS)) u_ly (
      .a_i(iy[g]), .b_i(iy[g+1]), .t_i(t_q), .y_o(l1_y[g]));
  end

  for (genvar g = 0; g < 2; g++) begin : g_lvl2
    pbf_lerp #(.FRAC_BITS(FRAC_BITS)) u_lx (
      .a_i(s1_x_q[g]), .b_i(s1_x_q[g+1]), .t_i(s1_t_q), .y_o(l2_x[g]));
    pbf_lerp #(.FRAC_BITS(FRAC_BITS)) u_ly (
      .a_i(s1_y_q[g]), .b_i(s1_y_q[g+1]), .t_i(s1_t_q), .y_o(l2_y[g]));
  end

  pbf_lerp #(.FRAC_BITS(FRAC_BITS)) u_l3x (
    .a_i(s2_x_q[0]), .b_i(s2_x_q[1]), .t_i(s2_t_q), .y_o(l3_x));
  pbf_lerp #(.FRAC_BITS(FRAC_BITS)) u_l3y (
    .a_i(s2_y_q[0]), .b_i(s2_y_q[1]), .t_i(s2_t_q), .y_o(l3_y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= job_v_q;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
      if (q_pop_o) begin
        job_v_q <= 1'b1;
      end else if (done) begin
        job_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (q_pop_o) begin
        job_q  <= q_data_i;
        step_q <= '0;
        t_q    <= '0;
        r_q    <= RW'(SEGMENTS / 2);
      end else if (job_v_q) begin
        step_q <= step_q + 1'b1;
        t_q    <= t_d;
        r_q    <= r_d;
      end
      s1_quad_q <= job_q.is_quad;
      s1_last_q <= done;
      s1_t_q    <= job_q.is_curve ? t_q : '0;
      for (int k = 0; k < 3; k++) begin
        s1_x_q[k] <= l1_x[k];
        s1_y_q[k] <= l1_y[k];
      end
      s2_quad_q <= s1_quad_q;
      s2_last_q <= s1_last_q;
      s2_t_q    <= s1_t_q;
      for (int k = 0; k < 2; k++) begin
        s2_x_q[k] <= l2_x[k];
        s2_y_q[k] <= l2_y[k];
      end
      out_last_q <= s2_last_q;
      out_x_q    <= s2_quad_q ? s2_x_q[0] : l3_x;
      out_y_q    <= s2_quad_q ? s2_y_q[0] : l3_y;
    end
  end

  assign out_valid_o  = out_v_q;
  assign point_x_o    = out_x_q;
  assign point_y_o    = out_y_q;
  assign last_point_o = out_last_q;

endmodule

// ----- rtl/pbf_checker.sv -----
// ----------------------------------------------------------------------------
// pbf_checker: port-level checks for the flattener
// Watches the output channel over time.
// ----------------------------------------------------------------------------
module pbf_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input pbf_pkg::coord_t point_x_o,
  input pbf_pkg::coord_t point_y_o,
  input logic            last_point_o
);
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(point_x_o) && $stable(point_y_o) && $stable(last_point_o))
    else $error("output payload changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind path_bezier_flattener_top pbf_checker u_pbf_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .point_x_o, .point_y_o,
  .last_point_o
);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the path bezier flattener
// Feeds path commands through a valid/ready request channel and predicts the
// emitted polyline points (pen, subpath start, control reflection, fixed-point
// de Casteljau), comparing every point field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned Segs      = 20;
  localparam int unsigned FracBits  = 16;
  localparam int          MaxCycles = 400000;
  localparam int          DrainWait = 40;
  localparam int          QuietFrom = 120;
  localparam int          QuietTo   = 200;

  typedef struct {
    logic [3:0]      mode;
    logic            rel;
    pbf_pkg::coord_t fx, fy, sx, sy, tx, ty;
    bit              hold_off;  // wait for every point before presenting this request
  } path_cmd_t;

  typedef struct {
    pbf_pkg::coord_t px, py;
    logic            last;
  } path_point_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [3:0]      mode_i = '0;
  logic            relative_i = 1'b0;
  pbf_pkg::coord_t first_x_i = '0, first_y_i = '0, second_x_i = '0, second_y_i = '0;
  pbf_pkg::coord_t third_x_i = '0, third_y_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  pbf_pkg::coord_t point_x_o, point_y_o;
  logic            last_point_o;

  path_bezier_flattener_top #(.SEGMENTS(Segs), .FRAC_BITS(FracBits)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .relative_i,
    .first_x_i, .first_y_i, .second_x_i, .second_y_i, .third_x_i, .third_y_i,
    .out_valid_o, .out_ready_i, .point_x_o, .point_y_o, .last_point_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: pen, subpath start, last control, point seen
  pbf_pkg::coord_t pen_x = '0, pen_y = '0, sub_x = '0, sub_y = '0;
  pbf_pkg::coord_t ctl_x = '0, ctl_y = '0;
  bit              drawn = 1'b0;

  path_cmd_t   pending_cmds[$];
  path_point_t expected_points[$];
  int          errors = 0;
  int          sent = 0;
  int          points_seen = 0;
  int          cycle = 0;
  bit          stim_done = 0;
  int          mode_hits[16];

  function automatic pbf_pkg::coord_t clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return pbf_pkg::coord_t'(v);
  endfunction

  // Offset a coordinate by the pen when the request is relative.
  function automatic pbf_pkg::coord_t place(pbf_pkg::coord_t v, pbf_pkg::coord_t p,
                                            logic rel);
    return rel ? clamp32(longint'(v) + longint'(p)) : v;
  endfunction

  // Reflect the stored control about the pen.
  function automatic pbf_pkg::coord_t mirror(pbf_pkg::coord_t p, pbf_pkg::coord_t c);
    return clamp32(2 * longint'(p) - longint'(c));
  endfunction

  // One interpolation step, rounding half up on a floor division.
  function automatic longint blend(longint a, longint b, longint t);
    longint prod;
    prod = (b - a) * t + (longint'(1) <<< (FracBits - 1));
    return a + (prod >>> FracBits);
  endfunction

  function automatic void push_point(pbf_pkg::coord_t x, pbf_pkg::coord_t y);
    path_point_t p;
    p.px = x; p.py = y; p.last = 1'b0;
    expected_points.insert(expected_points.size(), p);
  endfunction

  function automatic void queue_cmd(path_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Sample a cubic (order 4) or quadratic (order 3) curve at every t.
  function automatic void flatten_curve(longint cx[4], longint cy[4], int order);
    longint wx[4], wy[4], t;
    for (int i = 0; i <= Segs; i++) begin
      t = ((longint'(i) << FracBits) + Segs / 2) / Segs;
      wx = cx; wy = cy;
      for (int n = order - 1; n > 0; n--)
        for (int j = 0; j < n; j++) begin
          wx[j] = blend(wx[j], wx[j+1], t);
          wy[j] = blend(wy[j], wy[j+1], t);
        end
      push_point(pbf_pkg::coord_t'(wx[0]), pbf_pkg::coord_t'(wy[0]));
    end
  endfunction

  // Advance the predictor by one accepted request and queue its points.
  function automatic void predict_points(path_cmd_t c);
    pbf_pkg::coord_t ax, ay, bx, by, ex, ey;
    longint          cx[4], cy[4];
    int              prior_cnt;
    prior_cnt = expected_points.size();
    ax = place(c.fx, pen_x, c.rel); ay = place(c.fy, pen_y, c.rel);
    bx = place(c.sx, pen_x, c.rel); by = place(c.sy, pen_y, c.rel);
    ex = place(c.tx, pen_x, c.rel); ey = place(c.ty, pen_y, c.rel);
    cx[0] = pen_x; cy[0] = pen_y; cx[3] = 0; cy[3] = 0;
    case (c.mode)
      pbf_pkg::MODE_MOVE: begin
        pen_x = ax; pen_y = ay; sub_x = ax; sub_y = ay;
      end
      pbf_pkg::MODE_LINE: push_point(ax, ay);
      pbf_pkg::MODE_HLINE, pbf_pkg::MODE_VLINE: begin
        if (!drawn) push_point(pen_x, pen_y);
        if (c.mode == pbf_pkg::MODE_HLINE) push_point(ax, pen_y);
        else push_point(pen_x, ay);
      end
      pbf_pkg::MODE_CUBIC: begin
        cx[1] = ax; cy[1] = ay; cx[2] = bx; cy[2] = by; cx[3] = ex; cy[3] = ey;
        ctl_x = bx; ctl_y = by;
        flatten_curve(cx, cy, 4);
      end
      pbf_pkg::MODE_QUAD: begin
        cx[1] = ax; cy[1] = ay; cx[2] = bx; cy[2] = by;
        ctl_x = ax; ctl_y = ay;
        flatten_curve(cx, cy, 3);
      end
      pbf_pkg::MODE_SCUBIC: begin
        cx[1] = mirror(pen_x, ctl_x); cy[1] = mirror(pen_y, ctl_y);
        cx[2] = ax; cy[2] = ay; cx[3] = bx; cy[3] = by;
        ctl_x = ax; ctl_y = ay;
        flatten_curve(cx, cy, 4);
      end
      pbf_pkg::MODE_SQUAD: begin
        cx[1] = mirror(pen_x, ctl_x); cy[1] = mirror(pen_y, ctl_y);
        cx[2] = ax; cy[2] = ay;
        ctl_x = pbf_pkg::coord_t'(cx[1]); ctl_y = pbf_pkg::coord_t'(cy[1]);
        flatten_curve(cx, cy, 3);
      end
      pbf_pkg::MODE_CLOSE: push_point(sub_x, sub_y);
      default: ;
    endcase
    if (expected_points.size() > prior_cnt) begin
      expected_points[$].last = 1'b1;
      pen_x = expected_points[$].px;
      pen_y = expected_points[$].py;
      drawn = 1'b1;
    end
  endfunction

  function automatic pbf_pkg::coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return pbf_pkg::coord_t'($urandom);
      3: return pbf_pkg::coord_t'($urandom_range(0, 3)) - 32'sd1;
      default: return pbf_pkg::coord_t'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic path_cmd_t make_cmd(logic [3:0] m, logic r);
    path_cmd_t c;
    c.mode = m; c.rel = r; c.hold_off = 1'b0;
    c.fx = rand_coord(); c.fy = rand_coord();
    c.sx = rand_coord(); c.sy = rand_coord();
    c.tx = rand_coord(); c.ty = rand_coord();
    return c;
  endfunction

  // Build the request list: directed corners first, then random subpaths.
  initial begin
    path_cmd_t c;
    logic [3:0] m;
    // relative hline straight after reset: pen emitted first, offsets act absolute
    c = make_cmd(pbf_pkg::MODE_HLINE, 1'b1); c.fx = 32'sh0001_0000; queue_cmd(c);
    c = make_cmd(pbf_pkg::MODE_MOVE, 1'b1); c.fx = 32'sh7fffffff; c.fy = 32'sh80000000;
    queue_cmd(c);
    // relative sums that saturate at both ends
    c = make_cmd(pbf_pkg::MODE_LINE, 1'b1); c.fx = 32'sh7fffffff; c.fy = 32'sh80000000;
    queue_cmd(c);
    c = make_cmd(pbf_pkg::MODE_VLINE, 1'b0); c.fy = 32'sh0000_0000; queue_cmd(c);
    // smooth after a non-curve command: the stale control is reflected
    queue_cmd(make_cmd(pbf_pkg::MODE_SQUAD, 1'b0));
    queue_cmd(make_cmd(pbf_pkg::MODE_SCUBIC, 1'b1));
    c = make_cmd(pbf_pkg::MODE_CUBIC, 1'b0);
    c.fx = 32'sh80000000; c.fy = 32'sh7fffffff; c.sx = 32'sh7fffffff; c.sy = 32'sh80000000;
    c.tx = 32'sh80000000; c.ty = 32'sh80000000;
    queue_cmd(c);
    // reflection that clamps
    queue_cmd(make_cmd(pbf_pkg::MODE_SCUBIC, 1'b0));
    queue_cmd(make_cmd(pbf_pkg::MODE_QUAD, 1'b1));
    queue_cmd(make_cmd(pbf_pkg::MODE_SQUAD, 1'b1));
    c = make_cmd(pbf_pkg::MODE_CLOSE, 1'b1); c.hold_off = 1'b1; queue_cmd(c);
    // unused modes: nothing emitted, nothing changed
    for (int u = 9; u < 16; u++) queue_cmd(make_cmd(u[3:0], u[0]));
    queue_cmd(make_cmd(pbf_pkg::MODE_HLINE, 1'b0));
    queue_cmd(make_cmd(pbf_pkg::MODE_CUBIC, 1'b1));

    for (int k = 0; k < 44; k++) begin
      queue_cmd(make_cmd(pbf_pkg::MODE_MOVE, 1'($urandom_range(0, 1))));
      for (int j = $urandom_range(2, 6); j > 0; j--) begin
        m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(1, 7));
        queue_cmd(make_cmd(m, 1'($urandom_range(0, 1))));
      end
      if ($urandom_range(0, 2) != 0) queue_cmd(make_cmd(pbf_pkg::MODE_CLOSE, 1'b0));
      if (k == 20) pending_cmds[$].hold_off = 1'b1;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Request driver: hold the payload until accepted, idle at random outside
  // the quiet stretch, and honour hold-offs by draining all points first.
  always @(posedge clk_i) begin
    bit quiet;
    quiet = (cycle >= QuietFrom && cycle < QuietTo) || (sent >= 30 && sent < 70);
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        mode_hits[mode_i]++;
        predict_points(pending_cmds.pop_front());
        sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_cmds.size() == 0) begin
          in_valid_i <= 1'b0;
          stim_done  <= 1'b1;
        end else if ((pending_cmds[0].hold_off && expected_points.size() != 0) ||
                     (!quiet && $urandom_range(0, 99) < 14)) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          mode_i     <= pending_cmds[0].mode;
          relative_i <= pending_cmds[0].rel;
          first_x_i  <= pending_cmds[0].fx;
          first_y_i  <= pending_cmds[0].fy;
          second_x_i <= pending_cmds[0].sx;
          second_y_i <= pending_cmds[0].sy;
          third_x_i  <= pending_cmds[0].tx;
          third_y_i  <= pending_cmds[0].ty;
          pending_cmds[0].hold_off = 1'b0;
        end
      end
    end
  end

  // Point monitor: compare each accepted point with the oldest prediction,
  // stalling the output side at random outside the quiet stretch.
  always @(posedge clk_i) begin
    path_point_t want;
    cycle <= cycle + 1;
    if (rst_ni) begin
      out_ready_i <= (cycle >= QuietFrom && cycle < QuietTo) || ($urandom_range(0, 99) >= 14);
      if (out_valid_o && out_ready_i) begin
        points_seen++;
        if (expected_points.size() == 0) begin
          $error("unexpected point x=%0d y=%0d", point_x_o, point_y_o);
          errors++;
        end else begin
          want = expected_points.pop_front();
          if (point_x_o !== want.px) begin
            $error("point_x expected %0d got %0d", want.px, point_x_o); errors++;
          end
          if (point_y_o !== want.py) begin
            $error("point_y expected %0d got %0d", want.py, point_y_o); errors++;
          end
          if (last_point_o !== want.last) begin
            $error("last_point expected %0b got %0b", want.last, last_point_o); errors++;
          end
        end
      end
    end
  end

  // End of run: drain, allow the pipeline latency to settle, then report.
  initial begin
    fork
      begin
        wait (stim_done && expected_points.size() == 0);
        repeat (DrainWait) @(posedge clk_i);
        if (expected_points.size() != 0) errors++;
        $display("Sent %0d commands, checked %0d points.", sent, points_seen);
        $display("Cubic %0d, quad %0d, smooth %0d, lines %0d, close %0d.",
                 mode_hits[pbf_pkg::MODE_CUBIC], mode_hits[pbf_pkg::MODE_QUAD],
                 mode_hits[pbf_pkg::MODE_SCUBIC] + mode_hits[pbf_pkg::MODE_SQUAD],
                 mode_hits[pbf_pkg::MODE_LINE] + mode_hits[pbf_pkg::MODE_HLINE] +
                 mode_hits[pbf_pkg::MODE_VLINE],
                 mode_hits[pbf_pkg::MODE_CLOSE]);
        if (errors == 0) begin
          $display("[ OK ] regression clean");
        end else begin
          $display("[FAIL] regression broken");
        end
      end
      begin
        wait (cycle >= MaxCycles);
        $display("Timed out with %0d points outstanding.", expected_points.size());
        $display("[FAIL] regression broken");
      end
    join_any
    $finish;
  end

endmodule
